>>> hdl/aoa_pkg.sv
`timescale 1ns / 1ps

package aoa_pkg;

  // fixed field widths of the items
  localparam int CHANNEL_W = 3;
  localparam int SAMPLE_W  = 10;
  localparam int COUNT_W   = 8;
  localparam int AVG_W     = 10;

  // channel field mask and its complement
  localparam logic [COUNT_W-1:0] CH_FIELD_MASK = 8'h07;
  localparam logic [COUNT_W-1:0] CH_FIELD_HIGH = 8'hF8;

  typedef logic [CHANNEL_W-1:0] channel_t;
  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [AVG_W-1:0]     avg_t;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hdl/aoa_in_if.sv
`timescale 1ns / 1ps

interface aoa_in_if import aoa_pkg::*; ();
  logic     valid;
  logic     ready;
  channel_t channel;
  sample_t  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

>>> hdl/aoa_out_if.sv
`timescale 1ns / 1ps

interface aoa_out_if import aoa_pkg::*; ();
  logic   valid;
  logic   ready;
  avg_t   average;
  count_t used_count;
  logic   overflow;

  modport source (output valid, output average, output used_count, output overflow,
                  input ready);
  modport sink (input valid, input average, input used_count, input overflow,
                output ready);
endinterface

>>> hdl/aoa_cfg_if.sv
`timescale 1ns / 1ps

interface aoa_cfg_if import aoa_pkg::*; ();
  logic   valid;
  logic   ready;
  count_t sample_count;

  modport source (output valid, output sample_count, input ready);
  modport sink (input valid, input sample_count, output ready);
endinterface

>>> hdl/aoa_serial_div.sv
`timescale 1ns / 1ps

module aoa_serial_div import aoa_pkg::*; #(
  parameter int SUM_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SUM_BITS-1:0] dividend,
  input  count_t              divisor,
  output logic [SUM_BITS-1:0] quotient,
  output div_stat_t           stat
);

  localparam int CNT_W = $clog2(SUM_BITS);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(SUM_BITS - 1);

  logic [SUM_BITS-1:0] quo_r, quo_nxt;
  count_t              rem_r, rem_nxt;
  count_t              den_r, den_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [COUNT_W:0]    trial;
  logic [COUNT_W:0]    diff;

  // one quotient bit per cycle, restoring step
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[SUM_BITS-1]};
    diff     = trial - {1'b0, den_r};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[COUNT_W-1:0];
        quo_nxt = {quo_r[SUM_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[COUNT_W-1:0];
        quo_nxt = {quo_r[SUM_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_BIT) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> hdl/adc_oversample_averager_top.sv
`timescale 1ns / 1ps

// channel  port   direction  payload
// in       in_s   sink       channel[2:0], sample[9:0]
// out      out_s  source     average[9:0], used_count[7:0], overflow
// cfg      cfg_s  sink       sample_count[7:0], always ready
//
// a sample on a new channel only updates the remembered channel; any other sample
// goes through the bit-serial adder before the next item is taken
// an item that ends a run then goes through the serial divider, which an overflow
// with no samples skips, and S_DONE, which hands the result to the output register
// rst_n is synchronous; it clears sum, count, remembered channel, sample_count to 1
// input is taken only while the sequencer idles; a waiting result does not block it
// until the next run ends

module adc_oversample_averager_top import aoa_pkg::*; #(
  parameter int SAMPLE_BITS = 10,
  parameter int SUM_BITS    = 16,
  parameter int CHANNELS    = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  aoa_in_if.sink    in_s,
  aoa_out_if.source out_s,
  aoa_cfg_if.sink   cfg_s
);

  localparam int SMP_USE = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam sample_t SMP_MASK = SAMPLE_W'((1 << SMP_USE) - 1);
  localparam int CNT_W = $clog2(SUM_BITS);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(SUM_BITS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // channel reduced modulo the channel count, a few narrow subtract steps
  function automatic channel_t ch_reduce(input channel_t ch);
    logic [4:0] v;
    v = {2'b00, ch & CH_FIELD_MASK[CHANNEL_W-1:0]};
    for (int i = 0; i < 4; i++) begin
      if (v >= 5'(CHANNELS)) begin
        v = v - 5'(CHANNELS);
      end
    end
    return v[CHANNEL_W-1:0];
  endfunction

  logic [1:0]          state_r, state_nxt;
  channel_t            last_ch_r, last_ch_nxt;
  logic [SUM_BITS-1:0] sum_r, sum_nxt;
  logic [SUM_BITS-1:0] add_r, add_nxt;
  logic                carry_r, carry_nxt;
  logic [CNT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  count_t              taken_r, taken_nxt;
  count_t              smp_cnt_r, smp_cnt_nxt;
  count_t              res_cnt_r, res_cnt_nxt;
  logic                res_ovf_r, res_ovf_nxt;
  avg_t                out_avg_r, out_avg_nxt;
  count_t              out_cnt_r, out_cnt_nxt;
  logic                out_ovf_r, out_ovf_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                in_acc;
  channel_t            ch_in;
  logic                sbit;
  logic                cout;
  logic [SUM_BITS-1:0] sum_rot;
  logic [SUM_BITS-1:0] sum_new;
  count_t              cnt_inc;
  count_t              target;
  logic                div_start;
  logic [SUM_BITS-1:0] div_dividend;
  count_t              div_divisor;
  logic [SUM_BITS-1:0] div_quo;
  div_stat_t           div_stat;

  assign in_s.ready  = (state_r == S_IDLE);
  assign cfg_s.ready = 1'b1;
  assign in_acc      = in_s.valid && in_s.ready;
  assign ch_in       = ch_reduce(in_s.channel);

  // serial full adder and the values seen on the last bit
  assign sbit    = sum_r[0] ^ add_r[0] ^ carry_r;
  assign cout    = (sum_r[0] & add_r[0]) | (carry_r & (sum_r[0] ^ add_r[0]));
  assign sum_rot = {sum_r[0], sum_r[SUM_BITS-1:1]};
  assign sum_new = {sbit, add_r[SUM_BITS-1:1]};
  assign cnt_inc = taken_r + 1'b1;
  assign target  = (smp_cnt_r == '0) ? count_t'(1) : smp_cnt_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    last_ch_nxt   = last_ch_r;
    sum_nxt       = sum_r;
    add_nxt       = add_r;
    carry_nxt     = carry_r;
    bit_cnt_nxt   = bit_cnt_r;
    taken_nxt     = taken_r;
    smp_cnt_nxt   = smp_cnt_r;
    res_cnt_nxt   = res_cnt_r;
    res_ovf_nxt   = res_ovf_r;
    out_avg_nxt   = out_avg_r;
    out_cnt_nxt   = out_cnt_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    div_dividend  = sum_new;
    div_divisor   = cnt_inc;

    if (cfg_s.valid && cfg_s.ready) begin
      smp_cnt_nxt = cfg_s.sample_count;
    end

    if (out_valid_r && out_s.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (ch_in != last_ch_r) begin
            last_ch_nxt = ch_in;
          end else begin
            add_nxt     = {{(SUM_BITS-SAMPLE_W){1'b0}}, in_s.sample & SMP_MASK};
            carry_nxt   = 1'b0;
            bit_cnt_nxt = '0;
            state_nxt   = S_ADD;
          end
        end
      end
      S_ADD: begin
        sum_nxt     = sum_rot;
        add_nxt     = sum_new;
        carry_nxt   = cout;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == LAST_BIT) begin
          if (cout) begin
            // sum would wrap: drop the sample, average what was taken
            res_cnt_nxt  = taken_r;
            res_ovf_nxt  = 1'b1;
            div_dividend = sum_rot;
            div_divisor  = taken_r;
            div_start    = (taken_r != '0);
            sum_nxt      = '0;
            taken_nxt    = '0;
            state_nxt    = (taken_r != '0) ? S_DIV : S_DONE;
          end else if (cnt_inc >= target) begin
            res_cnt_nxt = cnt_inc;
            res_ovf_nxt = 1'b0;
            div_start   = 1'b1;
            sum_nxt     = '0;
            taken_nxt   = '0;
            state_nxt   = S_DIV;
          end else begin
            sum_nxt   = sum_new;
            taken_nxt = cnt_inc;
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_s.ready) begin
          out_avg_nxt   = (res_cnt_r == '0) ? avg_t'(0) : div_quo[AVG_W-1:0];
          out_cnt_nxt   = res_cnt_r;
          out_ovf_nxt   = res_ovf_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_ch_r   <= '0;
      sum_r       <= '0;
      taken_r     <= '0;
      smp_cnt_r   <= count_t'(1);
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      carry_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_ch_r   <= last_ch_nxt;
      sum_r       <= sum_nxt;
      taken_r     <= taken_nxt;
      smp_cnt_r   <= smp_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      carry_r     <= carry_nxt;
    end
    add_r     <= add_nxt;
    res_cnt_r <= res_cnt_nxt;
    res_ovf_r <= res_ovf_nxt;
    out_avg_r <= out_avg_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  aoa_serial_div #(
    .SUM_BITS (SUM_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign out_s.valid      = out_valid_r;
  assign out_s.average    = out_avg_r;
  assign out_s.used_count = out_cnt_r;
  assign out_s.overflow   = out_ovf_r;

  // an empty average only comes from a wrap on the first sample
  a_empty_is_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cnt_r == '0) |-> out_ovf_r)
    else $error("result with no samples but no overflow");

  // the divider is never restarted while it works
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // waiting on the divider means it is running or just finished
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("sequencer waits on an idle divider");

  // a run that ends normally took at least one sample
  a_full_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !res_ovf_r) |-> (res_cnt_r != '0))
    else $error("normal run end with zero samples");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import aoa_pkg::*;

  // serial add plus divider plus output hand-off, with margin
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int ITEMS_PER_RUN = 150;
  localparam int MODE_STEP     = 655;
  localparam int REPORT_MAX    = 10;

  typedef enum int {
    IDLE_SEND_LIGHT,
    IDLE_SEND_HEAVY,
    IDLE_NONE
  } idle_mode_t;

  typedef struct packed {
    channel_t channel;
    sample_t  sample;
  } adc_item_t;

  typedef struct packed {
    avg_t   average;
    count_t used_count;
    logic   overflow;
  } avg_result_t;

  logic clk = 1'b0;
  logic rst_n;

  aoa_in_if  in_ch ();
  aoa_out_if out_ch ();
  aoa_cfg_if cfg_ch ();

  adc_oversample_averager_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch),
    .cfg_s (cfg_ch)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  adc_item_t   pend_q[$];
  avg_result_t avg_expect_q[$];
  int          items_in = 0;
  int          err_cnt = 0;
  int          cycle_cnt;
  channel_t    gen_ch = 3'd3;

  // averager state as the bench tracks it
  channel_t    seen_ch = '0;
  logic [15:0] run_sum = '0;
  count_t      run_taken = '0;
  count_t      run_len = 8'd1;

  function automatic idle_mode_t idle_mode();
    if (items_in < MODE_STEP) return IDLE_SEND_LIGHT;
    if (items_in < 2 * MODE_STEP) return IDLE_SEND_HEAVY;
    return IDLE_NONE;
  endfunction

  function automatic bit sender_idle();
    case (idle_mode())
      IDLE_SEND_LIGHT: return $urandom_range(0, 99) < 18;
      IDLE_SEND_HEAVY: return $urandom_range(0, 99) < 56;
      default:         return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_idle();
    case (idle_mode())
      IDLE_SEND_LIGHT: return $urandom_range(0, 99) < 56;
      IDLE_SEND_HEAVY: return $urandom_range(0, 99) < 18;
      default:         return 1'b0;
    endcase
  endfunction

  // close the current run and queue its average
  task automatic close_run(input logic ovf);
    avg_result_t r;
    logic [15:0] quot;
    quot = (run_taken != '0) ? run_sum / {8'd0, run_taken} : 16'd0;
    r.average    = quot[AVG_W-1:0];
    r.used_count = run_taken;
    r.overflow   = ovf;
    avg_expect_q.push_back(r);
    run_sum   = '0;
    run_taken = '0;
  endtask

  // one accepted sample through the averager
  task automatic track_sample(input channel_t ch, input sample_t smp);
    logic [16:0] next_sum;
    count_t      target;
    target   = (run_len == '0) ? 8'd1 : run_len;
    next_sum = {1'b0, run_sum} + {7'd0, smp};
    if (ch != seen_ch) begin
      // mux settling: drop the sample, keep the run
      seen_ch = ch;
    end else if (next_sum[16]) begin
      close_run(1'b1);
    end else begin
      run_sum   = next_sum[15:0];
      run_taken = run_taken + 8'd1;
      if (run_taken >= target) close_run(1'b0);
    end
  endtask

  task automatic report_error(input string msg);
    if (err_cnt < REPORT_MAX) $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // input driver
  always @(posedge clk) begin : drive_in
    adc_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_sample(in_ch.channel, in_ch.sample);
        items_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pend_q.size() != 0 && !sender_idle()) begin
          nxt = pend_q.pop_front();
          in_ch.channel <= nxt.channel;
          in_ch.sample  <= nxt.sample;
          in_ch.valid   <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch_out
    avg_result_t got;
    avg_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.average, out_ch.used_count, out_ch.overflow};
        if (avg_expect_q.size() == 0) begin
          report_error($sformatf("unexpected item avg=%0d used=%0d ovf=%0b",
                                 got.average, got.used_count, got.overflow));
        end else begin
          want = avg_expect_q.pop_front();
          if (got !== want)
            report_error($sformatf("avg exp %0d got %0d, used exp %0d got %0d, ovf exp %0b got %0b",
                                   want.average, got.average, want.used_count,
                                   got.used_count, want.overflow, got.overflow));
        end
      end
      out_ch.ready <= !receiver_idle();
    end
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic add_item(input channel_t ch, input sample_t smp);
    adc_item_t it;
    it.channel = ch;
    it.sample  = smp;
    pend_q.push_back(it);
  endtask

  // hold off until every item is in and every average is out
  task automatic wait_quiet();
    do @(posedge clk);
    while (pend_q.size() != 0 || in_ch.valid || avg_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_run_length(input count_t len);
    cfg_ch.sample_count <= len;
    cfg_ch.valid        <= 1'b1;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    run_len = len;
  endtask

  // mostly steady channel with random samples, a few one-off channel hops
  task automatic fill_random(input int n, input bit high_bias);
    sample_t  smp;
    channel_t ch;
    int       pick;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) gen_ch = channel_t'($urandom_range(0, 7));
      ch = gen_ch;
      if ($urandom_range(0, 49) == 0) ch = channel_t'($urandom_range(0, 7));
      pick = $urandom_range(0, 9);
      if (high_bias && pick < 7) smp = sample_t'($urandom_range(768, 1023));
      else if (pick == 0) smp = '0;
      else if (pick == 1) smp = '1;
      else smp = sample_t'($urandom_range(0, 1023));
      add_item(ch, smp);
    end
  endtask

  initial begin : stimulus
    count_t run_plan[13];
    count_t len;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.channel       = '0;
    in_ch.sample        = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.sample_count = '0;
    run_plan = '{8'd255, 8'd1, 8'd8, 8'd0, 8'd128, 8'd2, 8'd255, 8'd37, 8'd1,
                 8'd64, 8'd0, 8'd0, 8'd200};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait_quiet();

    // single-sample runs, extremes and channel hops
    set_run_length(8'd1);
    add_item(3'd0, 10'd0);
    add_item(3'd0, 10'd1023);
    add_item(3'd7, 10'd5);
    add_item(3'd7, 10'd512);
    add_item(3'd2, 10'h2AA);
    add_item(3'd2, 10'h155);
    wait_quiet();

    // zero count behaves as one
    set_run_length(8'd0);
    add_item(3'd2, 10'd7);
    add_item(3'd2, 10'd1000);
    wait_quiet();

    // channel hop inside a run keeps the partial sum
    set_run_length(8'd3);
    add_item(3'd5, 10'd10);
    add_item(3'd5, 10'd10);
    add_item(3'd3, 10'd99);
    add_item(3'd3, 10'd20);
    add_item(3'd3, 10'd30);
    add_item(3'd3, 10'd100);
    add_item(3'd3, 10'd50);
    wait_quiet();

    // count lowered below samples already taken
    set_run_length(8'd1);
    add_item(3'd3, 10'd200);
    wait_quiet();

    // random runs over a spread of counts, high samples for wrap at large counts
    for (int p = 0; p < 13; p++) begin
      len = run_plan[p];
      if (p == 10 || p == 11) len = count_t'($urandom_range(1, 255));
      set_run_length(len);
      fill_random(ITEMS_PER_RUN, len >= 8'd128);
      wait_quiet();
    end

    if (avg_expect_q.size() != 0)
      report_error($sformatf("%0d averages never arrived", avg_expect_q.size()));
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> adc_oversample_averager_top.f
hdl/aoa_pkg.sv
hdl/aoa_in_if.sv
hdl/aoa_out_if.sv
hdl/aoa_cfg_if.sv
hdl/aoa_serial_div.sv
hdl/adc_oversample_averager_top.sv
bench/tb.sv
